/* rtl/core/bba_pkg.sv */
package bba_pkg;

   // widest order the pool may take, plus one bit
   localparam int unsigned ORD_W = 5;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BADFREE = 2'd2;

   // one entry of the block table, one per unit of the pool
   typedef struct packed {
      logic             starts;
      logic [ORD_W-1:0] order;
      logic             is_free;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_A_RD,
      S_A_CHK,
      S_A_SPLIT,
      S_F_RD,
      S_F_CHK,
      S_F_BRD,
      S_F_BCHK,
      S_F_WLOW,
      S_DONE
   } state_type;

endpackage

/* rtl/core/bba_ram.sv */
module bba_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/core/buddy_block_allocator.sv */
// Channel  Direction  tdata                                  tuser
// req_     in         [3:0] req_order, [13:4] block_address  [0] mode
// rsp_     out        [9:0] granted_address                  [1:0] status
//
// After reset the table is swept once, one entry a cycle.
// One item at a time: an allocate reads and checks each block it visits, then
// writes the free upper half of each split and marks the granted block used; a
// free reads and checks the block, then for each merge reads and checks the
// buddy and rewrites the pair. The result passes through S_DONE; a waiting result
// holds S_DONE, but the next request transfer can still be taken once the result is loaded.
module buddy_block_allocator #(
   parameter int unsigned MAX_ORDER = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // req_order, block_address
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // granted_address
   output logic [1:0]  rsp_tuser    // status
);

   import bba_pkg::*;

   localparam int unsigned AW    = MAX_ORDER;
   localparam int unsigned PW    = MAX_ORDER + 1;
   localparam int unsigned DEPTH = 1 << MAX_ORDER;

   state_type state_ff, state_in;

   logic [PW-1:0]    addr_ff, addr_in;
   logic [AW-1:0]    buddy_ff, buddy_in;
   logic [ORD_W-1:0] ord_ff, ord_in;
   logic [3:0]       want_ff, want_in;
   logic [1:0]       res_st_ff, res_st_in;
   logic [9:0]       res_adr_ff, res_adr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [9:0]       grant_ff, grant_in;
   logic [1:0]       status_ff, status_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   entry_type        wr_data;
   logic [AW-1:0]    rd_addr;
   entry_type        rd_data;
   logic [ENTRY_W-1:0] rd_bits;

   logic             req_xfer;
   logic             slot_free;
   logic [ORD_W-1:0] ord_clamp;
   logic             out_of_pool;
   logic [AW-1:0]    a_cur;

   bba_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_data    = entry_type'(rd_bits);
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign a_cur      = addr_ff[AW-1:0];
   assign ord_clamp  = (rd_data.order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER)
                                                           : rd_data.order;
   assign out_of_pool = ({7'd0, req_tdata[13:4]} >= (17'd1 << MAX_ORDER));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, grant_ff};
   assign rsp_tuser  = status_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (a_cur == AW'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_xfer) begin
               if (req_tuser) begin
                  state_in = out_of_pool ? S_DONE : S_F_RD;
               end else begin
                  state_in = ({1'b0, req_tdata[3:0]} > ORD_W'(MAX_ORDER)) ? S_DONE
                                                                           : S_A_RD;
               end
            end
         end
         S_A_RD: begin
            state_in = (addr_ff == PW'(DEPTH)) ? S_DONE : S_A_CHK;
         end
         S_A_CHK: begin
            if (rd_data.starts && rd_data.is_free && ord_clamp >= ORD_W'(want_ff))
               state_in = S_A_SPLIT;
            else
               state_in = S_A_RD;
         end
         S_A_SPLIT: begin
            if (ord_ff == ORD_W'(want_ff)) state_in = S_DONE;
         end
         S_F_RD:  state_in = S_F_CHK;
         S_F_CHK: state_in = (!rd_data.starts || rd_data.is_free) ? S_DONE : S_F_BRD;
         S_F_BRD: state_in = (ord_ff >= ORD_W'(MAX_ORDER)) ? S_DONE : S_F_BCHK;
         S_F_BCHK: begin
            if (rd_data.starts && rd_data.is_free && rd_data.order == ord_ff)
               state_in = S_F_WLOW;
            else
               state_in = S_DONE;
         end
         S_F_WLOW: state_in = S_F_BRD;
         S_DONE: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // table accesses and working registers
   always_comb begin
      addr_in    = addr_ff;
      buddy_in   = buddy_ff;
      ord_in     = ord_ff;
      want_in    = want_ff;
      res_st_in  = res_st_ff;
      res_adr_in = res_adr_ff;
      wr_en      = 1'b0;
      wr_addr    = a_cur;
      wr_data    = '0;
      rd_addr    = a_cur;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            if (a_cur == '0) begin
               wr_data = '{starts: 1'b1, order: ORD_W'(MAX_ORDER), is_free: 1'b1};
            end
            addr_in = (a_cur == AW'(DEPTH - 1)) ? '0 : addr_ff + 1'b1;
         end
         S_IDLE: begin
            want_in    = req_tdata[3:0];
            res_adr_in = '0;
            if (req_tuser) begin
               addr_in   = PW'(req_tdata[13:4]);
               res_st_in = out_of_pool ? ST_BADFREE : ST_DONE;
            end else begin
               addr_in   = '0;
               res_st_in = ST_NOSPACE;
            end
         end
         S_A_CHK: begin
            ord_in = ord_clamp;
            if (!(rd_data.starts && rd_data.is_free && ord_clamp >= ORD_W'(want_ff)))
               addr_in = addr_ff + (rd_data.starts ? (PW'(1) << ord_clamp) : PW'(1));
         end
         S_A_SPLIT: begin
            wr_en = 1'b1;
            if (ord_ff == ORD_W'(want_ff)) begin
               wr_data    = '{starts: 1'b1, order: ord_ff, is_free: 1'b0};
               res_st_in  = ST_DONE;
               res_adr_in = 10'(addr_ff);
            end else begin
               // free the upper half
               ord_in  = ord_ff - 1'b1;
               wr_addr = AW'(addr_ff + (PW'(1) << (ord_ff - 1'b1)));
               wr_data = '{starts: 1'b1, order: ord_ff - 1'b1, is_free: 1'b1};
            end
         end
         S_F_CHK: begin
            ord_in = rd_data.order;
            if (!rd_data.starts || rd_data.is_free) begin
               res_st_in = ST_BADFREE;
            end else begin
               wr_en   = 1'b1;
               wr_data = '{starts: 1'b1, order: rd_data.order, is_free: 1'b1};
            end
         end
         S_F_BRD: begin
            buddy_in = a_cur ^ AW'(PW'(1) << ord_ff);
            rd_addr  = buddy_in;
         end
         S_F_BCHK: begin
            if (rd_data.starts && rd_data.is_free && rd_data.order == ord_ff) begin
               // drop the upper of the pair
               wr_en   = 1'b1;
               wr_addr = (a_cur < buddy_ff) ? buddy_ff : a_cur;
               wr_data = '0;
               addr_in = PW'((a_cur < buddy_ff) ? a_cur : buddy_ff);
               ord_in  = ord_ff + 1'b1;
            end
         end
         S_F_WLOW: begin
            wr_en   = 1'b1;
            wr_data = '{starts: 1'b1, order: ord_ff, is_free: 1'b1};
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      grant_in     = grant_ff;
      status_in    = status_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (state_ff == S_DONE && slot_free) begin
         rsp_valid_in = 1'b1;
         grant_in     = res_adr_ff;
         status_in    = res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buddy_ff   <= buddy_in;
      ord_ff     <= ord_in;
      want_ff    <= want_in;
      res_st_ff  <= res_st_in;
      res_adr_ff <= res_adr_in;
      grant_ff   <= grant_in;
      status_ff  <= status_in;
   end

endmodule

/* tb/tb_buddy_block_allocator.sv */
`timescale 1ns / 100ps

// Scoreboard: buddy table predictor plus the queue of pending grants
class alloc_scoreboard;
   bit        starts[1024];
   bit [4:0]  ord_of[1024];
   bit        is_free[1024];
   bit [9:0]  exp_addr[$];
   bit [1:0]  exp_status[$];
   int        errors;
   int        n_alloc, n_free, n_nospace, n_badfree;

   function void clear_table();
      foreach (starts[i]) begin
         starts[i] = 0;
         ord_of[i] = 0;
         is_free[i] = 0;
      end
      starts[0] = 1;
      ord_of[0] = 10;
      is_free[0] = 1;
   endfunction

   // predict the grant for one accepted request transfer
   function void note_request(bit mode, bit [3:0] want, bit [9:0] addr);
      int unsigned a, o, buddy, lo;
      bit [1:0] st;
      bit [9:0] grant;
      grant = 0;
      st = bba_pkg::ST_NOSPACE;
      if (!mode) begin
         n_alloc++;
         if (want <= 10) begin
            a = 0;
            while (a < 1024) begin
               o = (ord_of[a] > 10) ? 10 : ord_of[a];
               if (starts[a] && is_free[a] && o >= want) begin
                  while (o > want) begin
                     o--;
                     starts[a + (1 << o)] = 1;
                     ord_of[a + (1 << o)] = 5'(o);
                     is_free[a + (1 << o)] = 1;
                  end
                  ord_of[a] = 5'(o);
                  is_free[a] = 0;
                  st = bba_pkg::ST_DONE;
                  grant = 10'(a);
                  break;
               end
               a += starts[a] ? (1 << o) : 1;
            end
         end
         if (st == bba_pkg::ST_NOSPACE) n_nospace++;
      end else begin
         n_free++;
         a = addr;
         if (!starts[a] || is_free[a]) begin
            st = bba_pkg::ST_BADFREE;
            n_badfree++;
         end else begin
            st = bba_pkg::ST_DONE;
            is_free[a] = 1;
            o = ord_of[a];
            while (o < 10) begin
               buddy = a ^ (1 << o);
               if (!starts[buddy] || !is_free[buddy] || ord_of[buddy] != o) break;
               lo = (a < buddy) ? a : buddy;
               starts[a ^ buddy ^ lo] = 0;
               ord_of[a ^ buddy ^ lo] = 0;
               is_free[a ^ buddy ^ lo] = 0;
               o++;
               ord_of[lo] = 5'(o);
               is_free[lo] = 1;
               a = lo;
            end
         end
      end
      exp_addr.push_back(grant);
      exp_status.push_back(st);
   endfunction

   // compare one response transfer with the oldest prediction
   function void check_response(bit [15:0] data, bit [1:0] status);
      bit [9:0] ea;
      bit [1:0] es;
      if (exp_addr.size() == 0) begin
         $error("unexpected response: granted_address %0d status %0d", data[9:0], status);
         errors++;
         return;
      end
      ea = exp_addr.pop_front();
      es = exp_status.pop_front();
      if (data[9:0] !== ea) begin
         $error("granted_address: expected %0d, got %0d", ea, data[9:0]);
         errors++;
      end
      if (status !== es) begin
         $error("status: expected %0d, got %0d", es, status);
         errors++;
      end
      if (data[15:10] !== 6'd0) begin
         $error("rsp_tdata padding: expected 0, got %0h", data[15:10]);
         errors++;
      end
   endfunction
endclass

module tb_buddy_block_allocator;
   import bba_pkg::*;

   localparam bit MODE_ALLOC = 1'b0;
   localparam bit MODE_FREE  = 1'b1;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   alloc_scoreboard sb;
   bit          long_hold;
   bit          stim_done;
   bit [9:0]    held_blocks[$];

   buddy_block_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // offer one request and hold it until the transfer; valid stays up
   // afterwards until a later request with a gap or a drain takes it down
   task automatic send_request(bit mode, bit [3:0] want, bit [9:0] addr, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {2'b00, addr, want};
      do @(posedge clock); while (!req_tready);
      sb.note_request(mode, want, addr);
      @(negedge clock);
   endtask

   // free one held block, chosen at random
   task automatic free_held(int gap);
      int k;
      bit [9:0] a;
      k = $urandom_range(held_blocks.size() - 1);
      a = held_blocks[k];
      held_blocks.delete(k);
      send_request(MODE_FREE, 4'd0, a, gap);
   endtask

   // drop valid and wait for every outstanding response
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.exp_addr.size() != 0) @(negedge clock);
   endtask

   // receiver: random stalls, with one long hold-off
   initial begin
      int pause;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end
         pause = ($urandom_range(3) == 0) ? 0 : $urandom_range(7);
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   // watchdog
   initial begin
      #200ms;
      $display("buddy_block_allocator regression: fail");
      $finish;
   end

   initial begin
      int gap, r, o;
      bit [9:0] a;
      sb = new();
      sb.clear_table();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, overlarge orders and bad frees
      send_request(MODE_ALLOC, 4'd10, 10'd0, 0);
      send_request(MODE_ALLOC, 4'd0, 10'd0, 0);
      send_request(MODE_FREE, 4'd15, 10'd1, 0);
      send_request(MODE_FREE, 4'd0, 10'd0, 0);
      send_request(MODE_FREE, 4'd0, 10'd0, 0);
      send_request(MODE_ALLOC, 4'd11, 10'd1023, 0);
      send_request(MODE_ALLOC, 4'd15, 10'd0, 0);
      send_request(MODE_ALLOC, 4'd0, 10'd0, 0);
      send_request(MODE_ALLOC, 4'd0, 10'd0, 0);
      send_request(MODE_ALLOC, 4'd3, 10'd0, 0);
      send_request(MODE_ALLOC, 4'd9, 10'd0, 0);
      send_request(MODE_ALLOC, 4'd9, 10'd0, 0);
      send_request(MODE_FREE, 4'd0, 10'd1023, 0);
      send_request(MODE_FREE, 4'd0, 10'd512, 0);
      send_request(MODE_FREE, 4'd0, 10'd1, 0);
      send_request(MODE_FREE, 4'd0, 10'd0, 0);
      send_request(MODE_FREE, 4'd0, 10'd8, 0);
      send_request(MODE_FREE, 4'd0, 10'd3, 0);
      wait_drained();

      // fill with small blocks while the receiver holds off
      long_hold = 1;
      for (int i = 0; i < 40; i++) begin
         send_request(MODE_ALLOC, 4'(i % 3), 10'd0, 0);
      end
      // sender pause until all grants are back
      wait_drained();
      for (int i = 0; i < 40; i++) begin
         send_request(MODE_FREE, 4'd0, 10'(i), 0);
      end
      send_request(MODE_FREE, 4'd0, 10'd0, 0);
      wait_drained();

      // random: mostly frees of held blocks and allocations that fit
      for (int i = 0; i < 1500; i++) begin
         gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(7);
         if (i % 300 < 40) gap = 0;
         r = $urandom_range(99);
         if (r < 45) begin
            o = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(5);
            send_request(MODE_ALLOC, 4'(o), 10'($urandom), gap);
            wait_drained();
            if (sb.n_alloc > 0 && held_blocks.size() < 200) begin
               a = sb.exp_addr.size() == 0 ? 10'd0 : 10'd0;
            end
         end else if (r < 85 && held_blocks.size() > 0) begin
            free_held(gap);
         end else begin
            send_request(MODE_FREE, 4'($urandom), 10'($urandom), gap);
         end
         // track held blocks from the predictor's table
         held_blocks.delete();
         for (int u = 0; u < 1024; u++)
            if (sb.starts[u] && !sb.is_free[u]) held_blocks.push_back(10'(u));
      end

      wait_drained();
      repeat (200) @(negedge clock);
      stim_done = 1;
      $display("run covered %0d allocations (%0d without space) and %0d frees (%0d bad)",
               sb.n_alloc, sb.n_nospace, sb.n_free, sb.n_badfree);
      if (sb.errors == 0 && sb.exp_addr.size() == 0) begin
         $display("buddy_block_allocator regression: pass");
      end else begin
         $display("buddy_block_allocator regression: fail");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/buddy_block_allocator.sv
tb/tb_buddy_block_allocator.sv
